FILE: design/b32e_pkg.sv
// Shared types and the character table of the base32 byte-to-character encoder.
package b32e_pkg;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       final_byte;
	} byte_item_t;

	typedef struct packed {
		logic [6:0] code_char;
		logic       final_char;
	} char_item_t;

	// Up to three characters produced from one byte, oldest in slot 0.
	typedef struct packed {
		logic [2:0][6:0] chars;
		logic [1:0]      count;
		logic            final_group;
	} char_group_t;

	function automatic logic [6:0] b32e_symbol(input logic [4:0] idx);
		logic [7:0] ch;
		unique case (idx)
			5'd0:  ch = "h";
			5'd1:  ch = "m";
			5'd2:  ch = "w";
			5'd3:  ch = "5";
			5'd4:  ch = "c";
			5'd5:  ch = "9";
			5'd6:  ch = "8";
			5'd7:  ch = "f";
			5'd8:  ch = "q";
			5'd9:  ch = "e";
			5'd10: ch = "6";
			5'd11: ch = "r";
			5'd12: ch = "3";
			5'd13: ch = "x";
			5'd14: ch = "t";
			5'd15: ch = "4";
			5'd16: ch = "y";
			5'd17: ch = "u";
			5'd18: ch = "p";
			5'd19: ch = "a";
			5'd20: ch = "d";
			5'd21: ch = "g";
			5'd22: ch = "j";
			5'd23: ch = "k";
			5'd24: ch = "7";
			5'd25: ch = "s";
			5'd26: ch = "l";
			5'd27: ch = "n";
			5'd28: ch = "b";
			5'd29: ch = "v";
			5'd30: ch = "2";
			5'd31: ch = "z";
		endcase
		return ch[6:0];
	endfunction

endpackage

FILE: design/b32e_pack.sv
// Splits the held bits plus one byte into five-bit groups and maps them to characters.
module b32e_pack import b32e_pkg::*; (
	input  logic [3:0]  held_bits,
	input  logic [2:0]  held_count,
	input  byte_item_t  item,
	output char_group_t group,
	output logic [3:0]  next_bits,
	output logic [2:0]  next_count
);

	logic [2:0]  cnt;
	logic [4:0]  mask;
	logic [11:0] acc;
	logic [3:0]  n;
	logic [3:0]  sh0;
	logic [3:0]  sh1;
	logic        two;
	logic [2:0]  rem;
	logic [2:0]  pad;
	logic [11:0] shifted0;
	logic [11:0] shifted1;
	logic [11:0] padded;
	logic [4:0]  r_mask;
	logic [6:0]  flush_char;
	logic        flush;

	always_comb begin
		cnt  = (held_count > 3'd4) ? 3'd4 : held_count;
		mask = (5'd1 << cnt) - 5'd1;
		acc  = {held_bits & mask[3:0], item.data_byte};
		n    = {1'b0, cnt} + 4'd8;
		sh0  = n - 4'd5;
		sh1  = n - 4'd10;
		two  = (n >= 4'd10);
		rem  = two ? sh1[2:0] : sh0[2:0];
		pad  = 3'd5 - rem;

		shifted0 = acc >> sh0;
		shifted1 = acc >> sh1;
		padded   = acc << pad;
		flush_char = b32e_symbol(padded[4:0]);
		// Leftover bits become one zero-padded character only at the end of a message.
		flush = item.final_byte && (rem != 3'd0);

		group.chars[0] = b32e_symbol(shifted0[4:0]);
		group.chars[1] = two ? b32e_symbol(shifted1[4:0]) : flush_char;
		group.chars[2] = flush_char;
		group.count    = (two ? 2'd2 : 2'd1) + {1'b0, flush};
		group.final_group = item.final_byte;

		r_mask = (5'd1 << rem) - 5'd1;
		if (item.final_byte) begin
			next_bits  = 4'd0;
			next_count = 3'd0;
		end else begin
			next_bits  = acc[3:0] & r_mask[3:0];
			next_count = rem;
		end
	end

endmodule

FILE: design/b32e_group.sv
// Result register: holds one byte's characters and hands them out one per cycle while char_ready is high.
module b32e_group import b32e_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        load,
	input  char_group_t group_in,
	output logic        free,
	output logic        char_valid,
	input  logic        char_ready,
	output char_item_t  char_item
);

	logic        valid_q;
	logic [1:0]  ptr_q;
	char_group_t group_q;
	logic        last_slot;

	assign last_slot  = (ptr_q == group_q.count - 2'd1);
	assign free       = !valid_q || (char_ready && last_slot);
	assign char_valid = valid_q;

	always_comb begin
		char_item.code_char  = group_q.chars[ptr_q];
		char_item.final_char = group_q.final_group && last_slot;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			ptr_q   <= 2'd0;
		end else if (load) begin
			valid_q <= 1'b1;
			ptr_q   <= 2'd0;
		end else if (valid_q && char_ready) begin
			if (last_slot) begin
				valid_q <= 1'b0;
			end
			ptr_q <= ptr_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			group_q <= group_in;
		end
	end

endmodule

FILE: design/base32_byte_to_char_encoder.sv
// Unpadded base32 encoder with a fixed custom alphabet. Each accepted byte goes into an
// input register, is combined with up to four bits held from earlier bytes and yields one
// or two characters, or up to three on the byte flagged as final, where leftover bits are
// zero-padded into one more character and the held bits are cleared. Characters leave one
// per cycle from a result register while char_ready is high; a new byte is taken as soon as
// the previous byte's last character is being delivered. A byte passes through the input
// register and then the result register before its first character appears. final_char
// marks the last character of each message.
module base32_byte_to_char_encoder import b32e_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       byte_valid,
	output logic       byte_ready,
	input  byte_item_t byte_item,
	output logic       char_valid,
	input  logic       char_ready,
	output char_item_t char_item
);

	logic        valid_s1;
	byte_item_t  item_s1;
	logic [3:0]  held_bits_q;
	logic [2:0]  held_count_q;
	logic [3:0]  next_bits;
	logic [2:0]  next_count;
	char_group_t group;
	logic        group_free;
	logic        advance;

	assign advance    = valid_s1 && group_free;
	assign byte_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			held_bits_q  <= 4'd0;
			held_count_q <= 3'd0;
		end else begin
			if (byte_ready) begin
				valid_s1 <= byte_valid;
			end
			if (advance) begin
				held_bits_q  <= next_bits;
				held_count_q <= next_count;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && byte_ready) begin
			item_s1 <= byte_item;
		end
	end

	b32e_pack u_pack (
		.held_bits  (held_bits_q),
		.held_count (held_count_q),
		.item       (item_s1),
		.group      (group),
		.next_bits  (next_bits),
		.next_count (next_count)
	);

	b32e_group u_group (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (advance),
		.group_in   (group),
		.free       (group_free),
		.char_valid (char_valid),
		.char_ready (char_ready),
		.char_item  (char_item)
	);

endmodule
